// ===== sv/bitmap_set_engine_assert.svh =====
// Assertion macros for the bitmap set engine.
// Used by bitmap_set_engine.sv; expects clk and rst_n in the including scope.
`ifndef BITMAP_SET_ENGINE_ASSERT_SVH
`define BITMAP_SET_ENGINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_set_engine: check failed");
// next-cycle implication
`define BSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_set_engine: check failed");
`else
`define BSE_ASSERT_IMP(lbl, ante, cons)
`define BSE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/bse_pkg.sv =====
// Shared types, constants and word-level helpers for the bitmap set engine.
// No dependencies; used by bse_word_unit and bitmap_set_engine.
`default_nettype none

package bse_pkg;

    localparam int SET_CAPACITY_DEF = 256;
    localparam int ELEM_W           = 8;
    localparam int ELEM_SPAN        = 1 << ELEM_W;
    localparam int KIND_W           = 4;
    localparam int COUNT_W          = 9;
    localparam int WORD_W           = 32;
    localparam int BIT_W            = $clog2(WORD_W);
    localparam int WIDX_W           = ELEM_W - BIT_W;
    localparam int POP_W            = BIT_W + 1;

    // operation codes carried in tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ASSIGN    = 4'd0,
        KIND_UNITE     = 4'd1,
        KIND_DIFF      = 4'd2,
        KIND_INTERSECT = 4'd3,
        KIND_INCLUDES  = 4'd4,
        KIND_INVERT    = 4'd5,
        KIND_COUNT     = 4'd6,
        KIND_NEXT      = 4'd7,
        KIND_CLEAR     = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // per-word request to the word unit
    typedef struct packed {
        kind_t             kind;
        logic [BIT_W-1:0]  bit_sel;   // element bit, or start bit for next member
        logic              first;     // word holds the search start
        logic              inv_full;  // word lies wholly below the universe word
        logic              inv_edge;  // word holds the universe bound
        logic [BIT_W-1:0]  inv_bit;   // universe bit inside its word
    } wu_req_t;

    // per-word response from the word unit
    typedef struct packed {
        logic [WORD_W-1:0] wr_data;
        logic              member;
        logic              hit;
        logic [BIT_W-1:0]  hit_bit;
        logic [POP_W-1:0]  pop;
    } wu_rsp_t;

    // population count of one nibble
    function automatic logic [2:0] nib_pop(input logic [3:0] n);
        logic [2:0] r;
        case (n)
            4'h0: r = 3'd0;
            4'h1, 4'h2, 4'h4, 4'h8: r = 3'd1;
            4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC: r = 3'd2;
            4'h7, 4'hB, 4'hD, 4'hE: r = 3'd3;
            4'hF: r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // bits 0..b set
    function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] b);
        logic [WORD_W-1:0] m;
        for (int j = 0; j < WORD_W; j++) begin
            m[j] = (BIT_W'(j) <= b);
        end
        return m;
    endfunction

    // bits b..top set
    function automatic logic [WORD_W-1:0] ge_mask(input logic [BIT_W-1:0] b);
        logic [WORD_W-1:0] m;
        for (int j = 0; j < WORD_W; j++) begin
            m[j] = (BIT_W'(j) >= b);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bse_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module bse_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bse_word_unit.sv =====
// Combinational per-word operator: bit set/clear, invert mask, popcount, first-member search.
// Depends on bse_pkg.
`default_nettype none

module bse_word_unit (
    input  wire logic [bse_pkg::WORD_W-1:0] word,
    input  wire bse_pkg::wu_req_t           req,
    output bse_pkg::wu_rsp_t                rsp
);

    logic [bse_pkg::WORD_W-1:0] onehot;
    logic [bse_pkg::WORD_W-1:0] inv_mask;
    logic [bse_pkg::WORD_W-1:0] wr_word;
    logic [bse_pkg::WORD_W-1:0] srch;
    logic [bse_pkg::POP_W-1:0]  pop_sum;
    logic [bse_pkg::BIT_W-1:0]  first_bit;

    assign onehot = bse_pkg::WORD_W'(1) << req.bit_sel;

    // invert keeps only bits up to the universe bound
    always_comb
    begin
        if (req.inv_full)
        begin
            inv_mask = '1;
        end
        else if (req.inv_edge)
        begin
            inv_mask = bse_pkg::low_mask(req.inv_bit);
        end
        else
        begin
            inv_mask = '0;
        end
    end

    // modified word for write-back
    always_comb
    begin
        case (req.kind)
            bse_pkg::KIND_UNITE:     wr_word = word | onehot;
            bse_pkg::KIND_DIFF:      wr_word = word & ~onehot;
            bse_pkg::KIND_INTERSECT: wr_word = word & onehot;
            bse_pkg::KIND_INVERT:    wr_word = ~word & inv_mask;
            default:                 wr_word = word;
        endcase
    end

    // popcount by nibbles
    always_comb
    begin
        pop_sum = '0;
        for (int n = 0; n < bse_pkg::WORD_W / 4; n++)
        begin
            pop_sum = pop_sum + bse_pkg::POP_W'(bse_pkg::nib_pop(word[n*4 +: 4]));
        end
    end

    // lowest set bit at or above the start bit (start applies in the first word only)
    assign srch = req.first ? (word & bse_pkg::ge_mask(req.bit_sel)) : word;

    always_comb
    begin
        first_bit = '0;
        for (int j = bse_pkg::WORD_W - 1; j >= 0; j--)
        begin
            if (srch[j])
            begin
                first_bit = bse_pkg::BIT_W'(j);
            end
        end
    end

    assign rsp.wr_data = wr_word;
    assign rsp.member  = word[req.bit_sel];
    assign rsp.hit     = |srch;
    assign rsp.hit_bit = first_bit;
    assign rsp.pop     = pop_sum;

endmodule

`default_nettype wire

// ===== sv/bitmap_set_engine.sv =====
// Bitmap set engine: one membership bitmap held in a word RAM, one operation per transfer.
// Depends on bse_pkg, bse_ram, bse_word_unit and bitmap_set_engine_assert.svh.
`default_nettype none
`include "bitmap_set_engine_assert.svh"

// The set lives in a RAM of 32-bit words (min(SET_CAPACITY, 256) bits, since element
// numbers are 8 bits), with one valid flop per word so that reset, clear, assign and
// intersect empty the set by clearing those flops rather than writing the RAM. The
// engine works on one operation at a time. Assign, clear and no-op codes go from
// transfer straight to result; unite, difference and intersect do one read-modify-write
// and includes one read. Invert and count stream every word (8 at a capacity of 256)
// through the single RAM read port; next-member streams from the start word and stops
// at the first word with a member.
// A finished result waits in an output register; the next operation is taken
// once that result has moved into it.
module bitmap_set_engine #(
    parameter int SET_CAPACITY = bse_pkg::SET_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] element, [15:8] universe
    input  wire logic [3:0]  s_axis_tuser,   // [3:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [0] is_member, [9:1] member_count,
                                             // [17:10] next_element, [18] found, rest 0
);

    localparam int CAP_BITS  = (SET_CAPACITY < bse_pkg::ELEM_SPAN) ?
                               SET_CAPACITY : bse_pkg::ELEM_SPAN;
    localparam int MEM_WORDS = (CAP_BITS + bse_pkg::WORD_W - 1) / bse_pkg::WORD_W;
    localparam int ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int VLD_N     = 1 << ADDR_W;
    localparam int ELEM_W    = bse_pkg::ELEM_W;
    localparam int BIT_W     = bse_pkg::BIT_W;
    localparam int WIDX_W    = bse_pkg::WIDX_W;
    localparam int COUNT_W   = bse_pkg::COUNT_W;

    localparam logic [ELEM_W-1:0]  CAP_TOP   = ELEM_W'(CAP_BITS - 1);
    localparam logic [ELEM_W:0]    CAP_LIM   = (ELEM_W + 1)'(CAP_BITS);
    localparam logic [WIDX_W:0]    WORD_LIM  = (WIDX_W + 1)'(MEM_WORDS);
    localparam logic [ADDR_W-1:0]  LAST_WORD = ADDR_W'(MEM_WORDS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(CAP_BITS);

    // ---------------- declarations ----------------
    bse_pkg::state_t state_reg, state_next;

    bse_pkg::kind_t        kind_reg, kind_next;
    logic [ELEM_W-1:0]     elem_reg, elem_next;
    logic [WIDX_W-1:0]     uword_reg, uword_next;
    logic [BIT_W-1:0]      ubit_reg, ubit_next;

    logic [ADDR_W-1:0]     iss_ptr_reg, iss_ptr_next;
    logic [ADDR_W-1:0]     last_ptr_reg, last_ptr_next;
    logic                  iss_left_reg, iss_left_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [VLD_N-1:0]      vld_reg, vld_next;

    logic                  acc_member_reg, acc_member_next;
    logic [COUNT_W-1:0]    acc_count_reg, acc_count_next;
    logic [ELEM_W-1:0]     acc_next_reg, acc_next_next;
    logic                  acc_found_reg, acc_found_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  out_member_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [ELEM_W-1:0]     out_next_reg;
    logic                  out_found_reg;

    logic                  in_xfer;
    logic                  scan_act;
    logic                  res_act;
    logic                  res_load;
    logic                  go_scan;
    logic                  scan_done;
    logic                  next_hit;

    bse_pkg::kind_t        in_kind;
    logic [ELEM_W-1:0]     in_elem;
    logic [ELEM_W-1:0]     in_univ;
    logic [ELEM_W-1:0]     in_ueff;
    logic [WIDX_W-1:0]     in_word;
    logic [BIT_W-1:0]      in_bit;
    logic                  in_elem_ok;
    logic                  in_word_ok;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [bse_pkg::WORD_W-1:0]    ram_wdata;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [bse_pkg::WORD_W-1:0]    ram_rdata;
    logic [bse_pkg::WORD_W-1:0]    rd_word;
    logic [WIDX_W-1:0]             rd_widx;

    bse_pkg::wu_req_t      wu_req;
    bse_pkg::wu_rsp_t      wu_rsp;

    // ---------------- input decode ----------------
    assign in_kind    = bse_pkg::kind_t'(s_axis_tuser);
    assign in_elem    = s_axis_tdata[7:0];
    assign in_univ    = s_axis_tdata[15:8];
    assign in_ueff    = (in_univ > CAP_TOP) ? CAP_TOP : in_univ;
    assign in_word    = in_elem[ELEM_W-1:BIT_W];
    assign in_bit     = in_elem[BIT_W-1:0];
    assign in_elem_ok = ({1'b0, in_elem} < CAP_LIM);
    assign in_word_ok = ({1'b0, in_word} < WORD_LIM);
    assign in_xfer    = s_axis_tvalid & s_axis_tready;

    // ---------------- FSM: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bse_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = go_scan ? bse_pkg::ST_SCAN : bse_pkg::ST_RESULT;
                end
            end
            bse_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = bse_pkg::ST_RESULT;
                end
            end
            bse_pkg::ST_RESULT:
            begin
                if (res_load)
                begin
                    state_next = bse_pkg::ST_IDLE;
                end
            end
            default: state_next = bse_pkg::ST_IDLE;
        endcase
    end

    // ---------------- FSM: outputs ----------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        scan_act      = 1'b0;
        res_act       = 1'b0;
        case (state_reg)
            bse_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            bse_pkg::ST_SCAN:   scan_act      = 1'b1;
            bse_pkg::ST_RESULT: res_act       = 1'b1;
            default:            s_axis_tready = 1'b0;
        endcase
    end

    assign res_load = res_act & (~m_valid_reg | m_axis_tready);

    // ---------------- bitmap RAM and word unit ----------------
    bse_ram #(
        .DATA_W (bse_pkg::WORD_W),
        .DEPTH  (MEM_WORDS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a word never written since the last emptying reads as zero
    assign rd_word = vld_reg[rd_addr_reg] ? ram_rdata : '0;
    assign rd_widx = WIDX_W'(rd_addr_reg);

    assign wu_req.kind     = kind_reg;
    assign wu_req.bit_sel  = elem_reg[BIT_W-1:0];
    assign wu_req.first    = (rd_widx == elem_reg[ELEM_W-1:BIT_W]);
    assign wu_req.inv_full = (rd_widx < uword_reg);
    assign wu_req.inv_edge = (rd_widx == uword_reg);
    assign wu_req.inv_bit  = ubit_reg;

    bse_word_unit u_word (
        .word (rd_word),
        .req  (wu_req),
        .rsp  (wu_rsp)
    );

    assign next_hit  = pend_reg & (kind_reg == bse_pkg::KIND_NEXT) & wu_rsp.hit;
    assign scan_done = pend_reg & (~iss_left_reg | next_hit);

    // ---------------- datapath control ----------------
    always_comb
    begin
        kind_next       = kind_reg;
        elem_next       = elem_reg;
        uword_next      = uword_reg;
        ubit_next       = ubit_reg;
        iss_ptr_next    = iss_ptr_reg;
        last_ptr_next   = last_ptr_reg;
        iss_left_next   = iss_left_reg;
        pend_next       = 1'b0;
        rd_addr_next    = rd_addr_reg;
        vld_next        = vld_reg;
        acc_member_next = acc_member_reg;
        acc_count_next  = acc_count_reg;
        acc_next_next   = acc_next_reg;
        acc_found_next  = acc_found_reg;
        go_scan         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = rd_addr_reg;
        ram_wdata       = wu_rsp.wr_data;
        ram_re          = 1'b0;
        ram_raddr       = iss_ptr_reg;

        // new transfer: latch operands, clear results, start or finish at once
        if (in_xfer)
        begin
            kind_next       = in_kind;
            elem_next       = in_elem;
            uword_next      = in_ueff[ELEM_W-1:BIT_W];
            ubit_next       = in_ueff[BIT_W-1:0];
            acc_member_next = 1'b0;
            acc_count_next  = '0;
            acc_next_next   = '0;
            acc_found_next  = 1'b0;
            iss_ptr_next    = ADDR_W'(in_word);
            last_ptr_next   = ADDR_W'(in_word);
            iss_left_next   = 1'b1;
            case (in_kind)
                bse_pkg::KIND_ASSIGN:
                begin
                    vld_next = '0;
                    if (in_elem_ok)
                    begin
                        ram_we                     = 1'b1;
                        ram_waddr                  = ADDR_W'(in_word);
                        ram_wdata                  = bse_pkg::WORD_W'(1) << in_bit;
                        vld_next[ADDR_W'(in_word)] = 1'b1;
                    end
                end
                bse_pkg::KIND_UNITE, bse_pkg::KIND_DIFF, bse_pkg::KIND_INCLUDES:
                begin
                    go_scan = in_elem_ok;
                end
                bse_pkg::KIND_INTERSECT:
                begin
                    go_scan = in_elem_ok;
                    if (!in_elem_ok)
                    begin
                        vld_next = '0;
                    end
                end
                bse_pkg::KIND_INVERT, bse_pkg::KIND_COUNT:
                begin
                    go_scan       = 1'b1;
                    iss_ptr_next  = '0;
                    last_ptr_next = LAST_WORD;
                end
                bse_pkg::KIND_NEXT:
                begin
                    go_scan       = in_word_ok;
                    last_ptr_next = LAST_WORD;
                end
                bse_pkg::KIND_CLEAR:
                begin
                    vld_next = '0;
                end
                default:
                begin
                    go_scan = 1'b0;
                end
            endcase
        end

        // scan: process the word read last cycle, issue the next read
        if (scan_act)
        begin
            if (pend_reg)
            begin
                case (kind_reg)
                    bse_pkg::KIND_UNITE, bse_pkg::KIND_DIFF, bse_pkg::KIND_INVERT:
                    begin
                        ram_we                = 1'b1;
                        vld_next[rd_addr_reg] = 1'b1;
                    end
                    bse_pkg::KIND_INTERSECT:
                    begin
                        ram_we                = 1'b1;
                        vld_next              = '0;
                        vld_next[rd_addr_reg] = 1'b1;
                    end
                    bse_pkg::KIND_INCLUDES:
                    begin
                        acc_member_next = wu_rsp.member;
                    end
                    bse_pkg::KIND_COUNT:
                    begin
                        acc_count_next = acc_count_reg + COUNT_W'(wu_rsp.pop);
                    end
                    bse_pkg::KIND_NEXT:
                    begin
                        if (wu_rsp.hit)
                        begin
                            acc_found_next = 1'b1;
                            acc_next_next  = ELEM_W'({rd_widx, wu_rsp.hit_bit});
                        end
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end

            ram_re = iss_left_reg & ~next_hit;
            if (ram_re)
            begin
                iss_ptr_next  = iss_ptr_reg + ADDR_W'(1);
                iss_left_next = (iss_ptr_reg != last_ptr_reg);
                rd_addr_next  = iss_ptr_reg;
            end
            pend_next = ram_re;
        end
    end

    assign m_valid_next = res_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bse_pkg::ST_IDLE;
            kind_reg       <= bse_pkg::KIND_CLEAR;
            iss_ptr_reg    <= '0;
            last_ptr_reg   <= '0;
            iss_left_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            rd_addr_reg    <= '0;
            vld_reg        <= '0;
            acc_member_reg <= 1'b0;
            acc_count_reg  <= '0;
            acc_next_reg   <= '0;
            acc_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            iss_ptr_reg    <= iss_ptr_next;
            last_ptr_reg   <= last_ptr_next;
            iss_left_reg   <= iss_left_next;
            pend_reg       <= pend_next;
            rd_addr_reg    <= rd_addr_next;
            vld_reg        <= vld_next;
            acc_member_reg <= acc_member_next;
            acc_count_reg  <= acc_count_next;
            acc_next_reg   <= acc_next_next;
            acc_found_reg  <= acc_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // ---------------- operand and result payload ----------------
    always_ff @(posedge clk)
    begin
        elem_reg  <= elem_next;
        uword_reg <= uword_next;
        ubit_reg  <= ubit_next;
        if (res_load)
        begin
            out_member_reg <= acc_member_reg;
            out_count_reg  <= acc_count_reg;
            out_next_reg   <= acc_next_reg;
            out_found_reg  <= acc_found_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, out_found_reg, out_next_reg, out_count_reg, out_member_reg};

    // ---------------- assertions ----------------
    `BSE_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
    `BSE_ASSERT_IMP(a_idle_no_pend, state_reg == bse_pkg::ST_IDLE, !pend_reg)
    `BSE_ASSERT_NXT(a_hold_result, res_act && m_valid_reg && !m_axis_tready, res_act)
    `BSE_ASSERT_IMP(a_count_bound, scan_act, acc_count_reg <= COUNT_MAX)

endmodule

`default_nettype wire

// ===== bench/bitmap_set_engine_test.sv =====
// Self-checking testbench for bitmap_set_engine: drives set operations over the input
// stream and checks every result against a bitmap predictor in the scoreboard class.
// Depends on bse_pkg and the bitmap_set_engine RTL.
`timescale 1ns / 100ps

// Scoreboard: mirrors the membership bitmap and queues the expected result per transfer
class bitmap_scoreboard;

    typedef struct packed {
        logic       found;
        logic [7:0] next_element;
        logic [8:0] member_count;
        logic       is_member;
    } outcome_t;

    bit [255:0] members;
    outcome_t   outcome_q[$];
    int         errors;
    int         ops_seen;
    int         results_seen;
    int         max_members;
    int         next_hits;
    int         next_misses;

    function new();
        members      = '0;
        errors       = 0;
        ops_seen     = 0;
        results_seen = 0;
        max_members  = 0;
        next_hits    = 0;
        next_misses  = 0;
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // apply one accepted operation to the mirror and queue its expected result
    function void note_input(logic [3:0] kind, logic [7:0] elem, logic [7:0] univ);
        outcome_t o;
        bit       had;
        int       n;
        o = '0;
        ops_seen++;
        case (kind)
            bse_pkg::KIND_ASSIGN:
            begin
                members       = '0;
                members[elem] = 1'b1;
            end
            bse_pkg::KIND_UNITE:     members[elem] = 1'b1;
            bse_pkg::KIND_DIFF:      members[elem] = 1'b0;
            bse_pkg::KIND_INTERSECT:
            begin
                had           = members[elem];
                members       = '0;
                members[elem] = had;
            end
            bse_pkg::KIND_INCLUDES:  o.is_member = members[elem];
            bse_pkg::KIND_INVERT:
            begin
                for (int i = 0; i < 256; i++)
                begin
                    members[i] = (i <= univ) ? ~members[i] : 1'b0;
                end
            end
            bse_pkg::KIND_COUNT:     o.member_count = 9'($countones(members));
            bse_pkg::KIND_NEXT:
            begin
                for (int i = elem; i < 256 && !o.found; i++)
                begin
                    if (members[i])
                    begin
                        o.found        = 1'b1;
                        o.next_element = i[7:0];
                    end
                end
                if (o.found)
                    next_hits++;
                else
                    next_misses++;
            end
            bse_pkg::KIND_CLEAR:     members = '0;
            default: ;  // unknown kind: no change, all-zero result
        endcase
        n = $countones(members);
        if (n > max_members)
            max_members = n;
        outcome_q.push_back(o);
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_result(logic [23:0] data);
        outcome_t o;
        results_seen++;
        if (outcome_q.size() == 0)
        begin
            note_error($sformatf("result with nothing expected: tdata=%h", data));
            return;
        end
        o = outcome_q.pop_front();
        if (data[0] !== o.is_member || data[9:1] !== o.member_count
            || data[17:10] !== o.next_element || data[18] !== o.found
            || data[23:19] !== 5'b0)
        begin
            note_error($sformatf({"result %0d: expected member=%0b count=%0d next=%0d ",
                "found=%0b, got member=%0b count=%0d next=%0d found=%0b pad=%h"},
                results_seen, o.is_member, o.member_count, o.next_element, o.found,
                data[0], data[9:1], data[17:10], data[18], data[23:19]));
        end
    endfunction

    // first member at or after start, wrapping; -1 when the set is empty
    function int member_near(int start);
        for (int k = 0; k < 256; k++)
        begin
            if (members[(start + k) % 256])
                return (start + k) % 256;
        end
        return -1;
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    // anything still queued at the end is a missing result
    function void close_out();
        if (outcome_q.size() != 0)
            note_error($sformatf("%0d results never arrived", outcome_q.size()));
    endfunction

endclass

module bitmap_set_engine_test;

    localparam int RANDOM_PER_PHASE = 388;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [7:0] element, [15:8] universe
    logic [3:0]  s_axis_tuser  = '0;   // [3:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;         // [0] is_member, [9:1] member_count,
                                       // [17:10] next_element, [18] found

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int directed_ops = 0;

    bitmap_scoreboard sb = new();

    bitmap_set_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: check each transfer, then pick the next ready level
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_op(input logic [3:0] kind, input logic [7:0] elem,
                           input logic [7:0] univ);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {univ, elem};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(kind, elem, univ);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // extremes, every kind, unknown kinds, searches with and without a hit
    task automatic run_directed();
        send_op(bse_pkg::KIND_COUNT,     8'd0,   8'd0);
        send_op(bse_pkg::KIND_NEXT,      8'd0,   8'd0);    // empty set: no candidate
        send_op(bse_pkg::KIND_INCLUDES,  8'd0,   8'd255);
        send_op(bse_pkg::KIND_UNITE,     8'd0,   8'd0);
        send_op(bse_pkg::KIND_UNITE,     8'd255, 8'd0);
        send_op(bse_pkg::KIND_INCLUDES,  8'd255, 8'd0);
        send_op(bse_pkg::KIND_INCLUDES,  8'd1,   8'd0);
        send_op(bse_pkg::KIND_NEXT,      8'd1,   8'd0);
        send_op(bse_pkg::KIND_NEXT,      8'd0,   8'd0);
        send_op(bse_pkg::KIND_COUNT,     8'd255, 8'd255);
        send_op(bse_pkg::KIND_DIFF,      8'd0,   8'd0);
        send_op(bse_pkg::KIND_INTERSECT, 8'd255, 8'd0);    // present: kept alone
        send_op(bse_pkg::KIND_INTERSECT, 8'd7,   8'd0);    // absent: set empties
        send_op(bse_pkg::KIND_ASSIGN,    8'd128, 8'd0);
        send_op(bse_pkg::KIND_INVERT,    8'd0,   8'd255);
        send_op(bse_pkg::KIND_COUNT,     8'd0,   8'd0);
        send_op(bse_pkg::KIND_NEXT,      8'd128, 8'd0);
        send_op(bse_pkg::KIND_INVERT,    8'd0,   8'd200);
        send_op(bse_pkg::KIND_NEXT,      8'd255, 8'd0);    // above universe: no hit
        send_op(bse_pkg::KIND_INVERT,    8'd0,   8'd0);
        send_op(4'd9,                    8'd255, 8'd255);  // unknown kinds
        send_op(4'd15,                   8'd170, 8'd85);
        send_op(bse_pkg::KIND_COUNT,     8'd0,   8'd0);
        send_op(bse_pkg::KIND_CLEAR,     8'd255, 8'd255);
        send_op(bse_pkg::KIND_COUNT,     8'd0,   8'd0);
        directed_ops = sb.ops_seen;
    endtask

    // weighted random op; elements lean toward members so queries hit often
    task automatic send_random_op();
        logic [3:0] kind;
        logic [7:0] elem;
        logic [7:0] univ;
        int         roll;
        int         near;
        roll = $urandom_range(0, 99);
        if (roll < 26)
            kind = bse_pkg::KIND_UNITE;
        else if (roll < 37)
            kind = bse_pkg::KIND_DIFF;
        else if (roll < 52)
            kind = bse_pkg::KIND_INCLUDES;
        else if (roll < 65)
            kind = bse_pkg::KIND_NEXT;
        else if (roll < 75)
            kind = bse_pkg::KIND_COUNT;
        else if (roll < 84)
            kind = bse_pkg::KIND_INVERT;
        else if (roll < 88)
            kind = bse_pkg::KIND_INTERSECT;
        else if (roll < 92)
            kind = bse_pkg::KIND_ASSIGN;
        else if (roll < 95)
            kind = bse_pkg::KIND_CLEAR;
        else
            kind = 4'($urandom_range(9, 15));

        roll = $urandom_range(0, 99);
        near = sb.member_near($urandom_range(0, 255));
        if (roll < 45 && near >= 0)
            elem = near[7:0];
        else if (roll < 60)
            elem = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else
            elem = 8'($urandom_range(0, 255));
        // a start just above a member exercises the search past it
        if (kind == bse_pkg::KIND_NEXT && $urandom_range(0, 3) == 0 && elem != 8'd255)
            elem = elem + 8'd1;

        roll = $urandom_range(0, 99);
        if (roll < 10)
            univ = 8'd0;
        else if (roll < 25)
            univ = 8'd255;
        else
            univ = 8'($urandom_range(0, 255));
        send_op(kind, elem, univ);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE)
            send_random_op();
    endtask

    // main sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(0, 0);
        // sender holds off until the engine has delivered everything
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();
        run_phase(74, 0);
        run_phase(0, 74);
        run_phase(23, 23);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        sb.close_out();

        $display("Ran %0d set operations (%0d directed), %0d results checked, %0d errors.",
                 sb.ops_seen, directed_ops, sb.results_seen, sb.errors);
        $display("Largest set held %0d members; next-member searches: %0d hits, %0d misses.",
                 sb.max_members, sb.next_hits, sb.next_misses);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
